[rtl/reachability_bit_matrix_assert.svh]
// Assertion macros for the reachability bit matrix.
// Both macros assume a clock named clk and an active-low reset named arst_n in scope.
`ifndef REACHABILITY_BIT_MATRIX_ASSERT_SVH
`define REACHABILITY_BIT_MATRIX_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RBM_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RBM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/rbm_pkg.sv]
// Shared types and constants for the reachability bit matrix.
// No dependencies; imported by the row unit and the top level.
package rbm_pkg;

	localparam int IDX_W = 6;

	localparam logic [2:0] OP_START   = 3'd0;
	localparam logic [2:0] OP_MERGE   = 3'd1;
	localparam logic [2:0] OP_COLLECT = 3'd2;
	localparam logic [2:0] OP_APPLY   = 3'd3;
	localparam logic [2:0] OP_QUERY   = 3'd4;

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_HOLD  = 6'b000100,
		ST_MOD   = 6'b001000,
		ST_APPLY = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	// Control of the shared row unit.
	typedef struct packed {
		logic keep;     // keep the stored row, otherwise it is replaced
		logic test_en;  // enable the overlap test against the test vector
	} alu_ctrl_t;

endpackage

[rtl/rbm_row_mem.sv]
// Row store of the reachability bit matrix: one write port, one registered read port.
// No package dependencies.
module rbm_row_mem #(
	parameter int DEPTH  = 64,
	parameter int WIDTH  = 64,
	parameter int ADDR_W = 6
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

[rtl/rbm_row_alu.sv]
// Shared row unit: merges an operand into a row and tests the row for overlap.
// Depends on rbm_pkg for the control struct.
module rbm_row_alu import rbm_pkg::*; #(
	parameter int WIDTH = 64
) (
	input  alu_ctrl_t        ctrl,
	input  logic [WIDTH-1:0] row,
	input  logic [WIDTH-1:0] operand,
	input  logic [WIDTH-1:0] test,
	output logic [WIDTH-1:0] out_row,
	output logic             meets
);

	assign out_row = (ctrl.keep ? row : '0) | operand;
	assign meets   = ctrl.test_en && ((row & test) != '0);

endmodule

[rtl/reachability_bit_matrix.sv]
// Reachability bit matrix: one ancestor row of NODES bits per node, held in a row memory with
// one write port and one registered read port, and worked on by one shared OR-and-test row unit
// under a small sequencer. After reset a clearing pass writes zero to every row, one row a
// cycle, so the block takes no transaction until the pass is done. Start, collect and query
// read the row, then modify or test it; merge reads two rows through the one read port, then
// modifies; and apply fusion walks every row, reading the next row while the current one is
// written back if it meets the collected mask. An operation with an index out of range, or an
// unused op code, reads no row and goes straight to its result. Every transaction gives exactly
// one result; connected is 1 only for a query whose source reaches its target. The result sits
// in an output register, so a new transaction may be taken while the previous result waits.
// Depends on rbm_pkg, rbm_row_mem, rbm_row_alu and reachability_bit_matrix_assert.svh.
`include "reachability_bit_matrix_assert.svh"

module reachability_bit_matrix import rbm_pkg::*; #(
	parameter int NODES = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  logic [2:0]       op,
	input  logic [IDX_W-1:0] node_index,
	input  logic [IDX_W-1:0] other_index,
	input  logic             self_input,
	output logic             result_valid,
	input  logic             result_stall,
	output logic             connected
);

	localparam int AW = $clog2(NODES);
	localparam int XW = (AW > IDX_W) ? AW : IDX_W;
	localparam logic [AW-1:0] LAST_ROW = AW'(NODES - 1);
	localparam logic [NODES-1:0] ONE_BIT = NODES'(1);

	state_t state_q, state_d;
	logic [2:0]       op_q;
	logic [AW-1:0]    node_q, other_q, cnt_q;
	logic             self_q;
	logic [NODES-1:0] opnd_q, acc_q, mask_q;
	logic             res_q, result_valid_q, connected_q;

	logic             accept, out_free, load_out, out_bit;
	logic             node_ok, other_ok;
	logic [XW-1:0]    node_x, other_x;
	logic [AW-1:0]    node_a, other_a;
	logic [NODES-1:0] node_oh, other_oh;
	logic             in_apply, apply_last;

	logic             rd_en, wr_en;
	logic [AW-1:0]    rd_addr, wr_addr;
	logic [NODES-1:0] rd_data, wr_data;

	alu_ctrl_t        alu_ctrl;
	logic [NODES-1:0] alu_operand, alu_test, alu_row;
	logic             alu_meets;

	assign item_stall   = (state_q != ST_IDLE);
	assign accept       = item_valid && !item_stall;
	assign out_free     = !result_valid_q || !result_stall;
	assign result_valid = result_valid_q;
	assign connected    = connected_q;

	assign node_ok  = (32'(node_index) < 32'(NODES));
	assign other_ok = (32'(other_index) < 32'(NODES));
	assign node_x   = XW'(node_index);
	assign other_x  = XW'(other_index);
	assign node_a   = node_x[AW-1:0];
	assign other_a  = other_x[AW-1:0];
	assign node_oh  = ONE_BIT << node_q;
	assign other_oh = ONE_BIT << other_q;

	assign in_apply   = (state_q == ST_APPLY);
	assign apply_last = in_apply && (cnt_q == LAST_ROW);

	rbm_row_mem #(
		.DEPTH  (NODES),
		.WIDTH  (NODES),
		.ADDR_W (AW)
	) u_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	rbm_row_alu #(
		.WIDTH (NODES)
	) u_alu (
		.ctrl    (alu_ctrl),
		.row     (rd_data),
		.operand (alu_operand),
		.test    (alu_test),
		.out_row (alu_row),
		.meets   (alu_meets)
	);

	always_comb begin
		state_d          = state_q;
		rd_en            = 1'b0;
		rd_addr          = node_q;
		wr_en            = 1'b0;
		wr_addr          = node_q;
		wr_data          = alu_row;
		alu_ctrl.keep    = 1'b1;
		alu_ctrl.test_en = 1'b0;
		alu_operand      = opnd_q;
		alu_test         = '0;
		load_out         = 1'b0;
		out_bit          = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = cnt_q;
				wr_data = '0;
				if (cnt_q == LAST_ROW) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					rd_addr = node_a;
					case (op)
						OP_START, OP_COLLECT: begin
							rd_en   = node_ok;
							state_d = node_ok ? ST_MOD : ST_DONE;
						end
						OP_MERGE: begin
							// The input row is read first and held as the operand.
							rd_addr = other_a;
							if (node_ok && other_ok && (node_index != other_index)) begin
								rd_en   = 1'b1;
								state_d = ST_HOLD;
							end else begin
								state_d = ST_DONE;
							end
						end
						OP_APPLY: begin
							rd_en   = 1'b1;
							rd_addr = '0;
							state_d = ST_APPLY;
						end
						OP_QUERY: begin
							rd_en   = node_ok && other_ok;
							state_d = (node_ok && other_ok) ? ST_MOD : ST_DONE;
						end
						default: begin
							state_d = ST_DONE;
						end
					endcase
				end
			end
			ST_HOLD: begin
				rd_en   = 1'b1;
				state_d = ST_MOD;
			end
			ST_MOD: begin
				case (op_q)
					OP_START: begin
						alu_ctrl.keep = self_q;
						alu_operand   = node_oh;
						wr_en         = 1'b1;
					end
					OP_MERGE: begin
						wr_en = 1'b1;
					end
					OP_COLLECT: begin
						alu_operand = acc_q;
					end
					OP_QUERY: begin
						alu_operand      = '0;
						alu_ctrl.test_en = 1'b1;
						alu_test         = other_oh;
						out_bit          = alu_meets;
					end
					default: begin
						alu_operand = '0;
					end
				endcase
				load_out = out_free;
				state_d  = out_free ? ST_IDLE : ST_DONE;
			end
			ST_APPLY: begin
				// Row cnt_q is written back, if it meets the mask, while row cnt_q + 1 is being read.
				alu_operand      = acc_q;
				alu_ctrl.test_en = 1'b1;
				alu_test         = mask_q;
				wr_en            = alu_meets;
				wr_addr          = cnt_q;
				if (cnt_q != LAST_ROW) begin
					rd_en   = 1'b1;
					rd_addr = cnt_q + AW'(1);
				end else begin
					load_out = out_free;
					state_d  = out_free ? ST_IDLE : ST_DONE;
				end
			end
			ST_DONE: begin
				out_bit  = res_q;
				load_out = out_free;
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			cnt_q          <= '0;
			acc_q          <= '0;
			mask_q         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR && cnt_q != LAST_ROW) begin
				cnt_q <= cnt_q + AW'(1);
			end else if (accept) begin
				cnt_q <= '0;
			end else if (state_q == ST_APPLY && cnt_q != LAST_ROW) begin
				cnt_q <= cnt_q + AW'(1);
			end
			if (state_q == ST_MOD && op_q == OP_COLLECT) begin
				acc_q  <= alu_row;
				mask_q <= mask_q | node_oh;
			end else if (apply_last) begin
				acc_q  <= '0;
				mask_q <= '0;
			end
			if (load_out) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= op;
			node_q  <= node_a;
			other_q <= other_a;
			self_q  <= self_input;
		end
		if (state_q == ST_HOLD) begin
			opnd_q <= rd_data;
		end
		if (state_q != ST_DONE) begin
			res_q <= out_bit;
		end
		if (load_out) begin
			connected_q <= out_bit;
		end
	end

	`RBM_ASSERT_NEXT(a_apply_walk, (in_apply && !apply_last), (in_apply), "walk left early")
	`RBM_ASSERT_NEXT(a_apply_clear, apply_last, (acc_q == '0 && mask_q == '0), "fusion not cleared")
	`RBM_ASSERT_SAME(a_no_collide, (rd_en && wr_en), (rd_addr != wr_addr), "read and write collide")

endmodule
